// ===== rtl/assert_macros.svh =====
// Assertion macros for the texel albedo sampler checkers.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define BTAS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define BTAS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/btas_pkg.sv =====
// Shared constants and types for the texel albedo sampler.
// No dependencies; used by the top level, the channel scaler and the checker.
`timescale 1ns / 1ps

package btas_pkg;

    localparam int MAX_WIDTH         = 256;
    localparam int MAX_HEIGHT        = 256;
    localparam int STORE_DEPTH_DEF   = 65536;

    localparam int IN_TDATA_W        = 208;
    localparam int OUT_TDATA_W       = 72;
    localparam int CFG_ADDR_W        = 5;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
    localparam logic [7:0]  BYTE_ONE = 8'hFF;
    localparam logic [24:0] ROUND_BIAS = 25'd127;
    // ceil(2^32 / 255), exact for numerators below 2^32 / 254
    localparam logic [24:0] RECIP_255  = 25'd16843010;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_TEX_PRES = 3'd2;
    localparam logic [2:0] REG_ALP_PRES = 3'd3;
    localparam logic [2:0] REG_FACTOR_R = 3'd4;
    localparam logic [2:0] REG_FACTOR_G = 3'd5;
    localparam logic [2:0] REG_FACTOR_B = 3'd6;
    localparam logic [2:0] REG_FACTOR_A = 3'd7;

    typedef struct packed {
        logic ld_mul;
        logic ld_div;
    } t_chan_ctl;

endpackage

// ===== rtl/btas_chan.sv =====
// One color channel: factor times byte, then rounded division by 255.
// Two pipeline stages; depends on btas_pkg.
`timescale 1ns / 1ps

module btas_chan (
    input  logic                 i_clk,
    input  btas_pkg::t_chan_ctl  i_ctl,
    input  logic [16:0]          i_factor,
    input  logic [7:0]           i_byte,
    output logic [16:0]          o_albedo
);

    logic [24:0] r_num;
    logic [16:0] r_quot;
    logic [24:0] n_num;
    logic [49:0] n_prod;

    assign n_num  = ({8'b0, i_factor} * {17'b0, i_byte}) + btas_pkg::ROUND_BIAS;
    assign n_prod = {25'b0, r_num} * {25'b0, btas_pkg::RECIP_255};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_num <= n_num;
        end
        if (i_ctl.ld_div) begin
            r_quot <= n_prod[48:32];
        end
    end

    assign o_albedo = r_quot;

endmodule

// ===== rtl/barycentric_texel_albedo_sampler.sv =====
// Barycentric texel albedo sampler: texture store, UV interpolation, texel fetch, scaling.
// Depends on btas_pkg and btas_chan.
`timescale 1ns / 1ps

// Takes one beat per cycle unless the output stalls, and sends one result beat per sample
// beat; write beats load one texel and send nothing. The eight register stages are:
// capture, six UV products, sum and clamp, column and row scaling, texel address, texture
// memory access, factor multiply, division by 255. The texture memory has a single port,
// used by whichever beat is in the access stage, so a write is seen by every later sample.
// Stages advance independently, so bubbles close up while the output stalls. The store is
// not cleared after reset: a texel reads as unknown until written. Registers are to be
// written over the APB port only while no beat is in flight; the block does not check this.
module barycentric_texel_albedo_sampler #(
    parameter int STORE_DEPTH = btas_pkg::STORE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // weight_a, weight_b, weight_c, vert_a_u, vert_a_v, vert_b_u, vert_b_v,
    // vert_c_u, vert_c_v, write_address, write_texel, zero pad
    input  logic [btas_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // action
    input  logic [0:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // albedo_red, albedo_green, albedo_blue, albedo_alpha, zero pad
    output logic [btas_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btas_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // configuration
    logic [8:0]  r_width;
    logic [8:0]  r_height;
    logic        r_tex_pres;
    logic        r_alp_pres;
    logic [16:0] r_fac_r;
    logic [16:0] r_fac_g;
    logic [16:0] r_fac_b;
    logic [16:0] r_fac_a;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 9'd1;
            r_height   <= 9'd1;
            r_tex_pres <= 1'b0;
            r_alp_pres <= 1'b0;
            r_fac_r    <= btas_pkg::ONE_Q16;
            r_fac_g    <= btas_pkg::ONE_Q16;
            r_fac_b    <= btas_pkg::ONE_Q16;
            r_fac_a    <= btas_pkg::ONE_Q16;
        end else if (cfg_wr) begin
            case (cfg_idx)
                btas_pkg::REG_WIDTH:    r_width    <= pwdata[8:0];
                btas_pkg::REG_HEIGHT:   r_height   <= pwdata[8:0];
                btas_pkg::REG_TEX_PRES: r_tex_pres <= pwdata[0];
                btas_pkg::REG_ALP_PRES: r_alp_pres <= pwdata[0];
                btas_pkg::REG_FACTOR_R: r_fac_r    <= pwdata[16:0];
                btas_pkg::REG_FACTOR_G: r_fac_g    <= pwdata[16:0];
                btas_pkg::REG_FACTOR_B: r_fac_b    <= pwdata[16:0];
                btas_pkg::REG_FACTOR_A: r_fac_a    <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            btas_pkg::REG_WIDTH:    prdata = {23'b0, r_width};
            btas_pkg::REG_HEIGHT:   prdata = {23'b0, r_height};
            btas_pkg::REG_TEX_PRES: prdata = {31'b0, r_tex_pres};
            btas_pkg::REG_ALP_PRES: prdata = {31'b0, r_alp_pres};
            btas_pkg::REG_FACTOR_R: prdata = {15'b0, r_fac_r};
            btas_pkg::REG_FACTOR_G: prdata = {15'b0, r_fac_g};
            btas_pkg::REG_FACTOR_B: prdata = {15'b0, r_fac_b};
            btas_pkg::REG_FACTOR_A: prdata = {15'b0, r_fac_a};
            default:                prdata = 32'b0;
        endcase
    end

    // effective dimensions: zero reads as one, saturate at the maximum
    logic [8:0] w_eff;
    logic [8:0] h_eff;

    always_comb begin
        if (r_width == 9'd0) begin
            w_eff = 9'd1;
        end else if ({23'b0, r_width} > 32'(btas_pkg::MAX_WIDTH)) begin
            w_eff = 9'(btas_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == 9'd0) begin
            h_eff = 9'd1;
        end else if ({23'b0, r_height} > 32'(btas_pkg::MAX_HEIGHT)) begin
            h_eff = 9'(btas_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // stage handshake: a stage loads when empty or when the next one advances
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

    assign rdy8 = !r_v8 || i_m_tready;
    assign rdy7 = !r_v7 || rdy8;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_s_tready = rdy1;

    logic r_act1, r_act2, r_act3, r_act4, r_act5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            // drop write beats once they reach memory
            if (rdy6) r_v6 <= r_v5 && (r_act5 == btas_pkg::ACT_SAMPLE);
            if (rdy7) r_v7 <= r_v6;
            if (rdy8) r_v8 <= r_v7;
        end
    end

    // stage 1: capture
    logic [16:0] r_wa1, r_wb1, r_wc1;
    logic [16:0] r_au1, r_av1, r_bu1, r_bv1, r_cu1, r_cv1;
    logic [15:0] r_wad1;
    logic [31:0] r_wt1;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_act1 <= i_s_tuser[0];
            r_wa1  <= i_s_tdata[16:0];
            r_wb1  <= i_s_tdata[33:17];
            r_wc1  <= i_s_tdata[50:34];
            r_au1  <= i_s_tdata[67:51];
            r_av1  <= i_s_tdata[84:68];
            r_bu1  <= i_s_tdata[101:85];
            r_bv1  <= i_s_tdata[118:102];
            r_cu1  <= i_s_tdata[135:119];
            r_cv1  <= i_s_tdata[152:136];
            r_wad1 <= i_s_tdata[168:153];
            r_wt1  <= i_s_tdata[200:169];
        end
    end

    // stage 2: weight times coordinate, Q2.32
    logic [33:0] r_pua2, r_pub2, r_puc2, r_pva2, r_pvb2, r_pvc2;
    logic [15:0] r_wad2;
    logic [31:0] r_wt2;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_act2 <= r_act1;
            r_wad2 <= r_wad1;
            r_wt2  <= r_wt1;
            r_pua2 <= {17'b0, r_wa1} * {17'b0, r_au1};
            r_pub2 <= {17'b0, r_wb1} * {17'b0, r_bu1};
            r_puc2 <= {17'b0, r_wc1} * {17'b0, r_cu1};
            r_pva2 <= {17'b0, r_wa1} * {17'b0, r_av1};
            r_pvb2 <= {17'b0, r_wb1} * {17'b0, r_bv1};
            r_pvc2 <= {17'b0, r_wc1} * {17'b0, r_cv1};
        end
    end

    // stage 3: sum and clamp to one
    logic [35:0] n_su3, n_sv3;
    logic [32:0] r_u3, r_v3c;
    logic [15:0] r_wad3;
    logic [31:0] r_wt3;

    assign n_su3 = {2'b0, r_pua2} + {2'b0, r_pub2} + {2'b0, r_puc2};
    assign n_sv3 = {2'b0, r_pva2} + {2'b0, r_pvb2} + {2'b0, r_pvc2};

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_act3 <= r_act2;
            r_wad3 <= r_wad2;
            r_wt3  <= r_wt2;
            r_u3   <= (n_su3 > {3'b0, btas_pkg::ONE_Q32}) ? btas_pkg::ONE_Q32 : n_su3[32:0];
            r_v3c  <= (n_sv3 > {3'b0, btas_pkg::ONE_Q32}) ? btas_pkg::ONE_Q32 : n_sv3[32:0];
        end
    end

    // stage 4: column and row, truncated
    logic [41:0] n_px4, n_py4;
    logic [8:0]  r_x4, r_y4;
    logic [15:0] r_wad4;
    logic [31:0] r_wt4;

    assign n_px4 = {9'b0, r_u3}  * {33'b0, w_eff - 9'd1};
    assign n_py4 = {9'b0, r_v3c} * {33'b0, h_eff - 9'd1};

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_act4 <= r_act3;
            r_wad4 <= r_wad3;
            r_wt4  <= r_wt3;
            r_x4   <= n_px4[40:32];
            r_y4   <= n_py4[40:32];
        end
    end

    // stage 5: texel address and range check
    logic [17:0]       n_saddr5;
    logic [31:0]       n_addr5;
    logic [ADDR_W-1:0] r_maddr5;
    logic              r_inr5;
    logic [31:0]       r_wt5;

    assign n_saddr5 = ({9'b0, r_y4} * {9'b0, w_eff}) + {9'b0, r_x4};
    assign n_addr5  = (r_act4 == btas_pkg::ACT_WRITE) ? {16'b0, r_wad4} : {14'b0, n_saddr5};

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_act5   <= r_act4;
            r_wt5    <= r_wt4;
            r_maddr5 <= n_addr5[ADDR_W-1:0];
            r_inr5   <= n_addr5 < 32'(STORE_DEPTH);
        end
    end

    // stage 6: texture memory, one access per beat
    logic [31:0] mem [STORE_DEPTH];
    logic [31:0] r_rdata6;
    logic        r_zero6;

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            if (r_v5 && (r_act5 == btas_pkg::ACT_WRITE) && r_inr5) begin
                mem[r_maddr5] <= r_wt5;
            end
            r_rdata6 <= mem[r_maddr5];
            r_zero6  <= !r_inr5;
        end
    end

    // stages 7 and 8: per-channel scaling
    logic [31:0] texel;
    logic [7:0]  byte_r, byte_g, byte_b, byte_a;
    logic [16:0] fs_r, fs_g, fs_b, fs_a;
    logic [16:0] alb_r, alb_g, alb_b, alb_a;
    btas_pkg::t_chan_ctl chan_ctl;

    assign texel  = r_zero6 ? 32'b0 : r_rdata6;
    assign byte_r = r_tex_pres ? texel[7:0]   : btas_pkg::BYTE_ONE;
    assign byte_g = r_tex_pres ? texel[15:8]  : btas_pkg::BYTE_ONE;
    assign byte_b = r_tex_pres ? texel[23:16] : btas_pkg::BYTE_ONE;
    assign byte_a = (r_tex_pres && r_alp_pres) ? texel[31:24] : btas_pkg::BYTE_ONE;

    assign fs_r = (r_fac_r > btas_pkg::ONE_Q16) ? btas_pkg::ONE_Q16 : r_fac_r;
    assign fs_g = (r_fac_g > btas_pkg::ONE_Q16) ? btas_pkg::ONE_Q16 : r_fac_g;
    assign fs_b = (r_fac_b > btas_pkg::ONE_Q16) ? btas_pkg::ONE_Q16 : r_fac_b;
    assign fs_a = (r_fac_a > btas_pkg::ONE_Q16) ? btas_pkg::ONE_Q16 : r_fac_a;

    assign chan_ctl.ld_mul = rdy7;
    assign chan_ctl.ld_div = rdy8;

    btas_chan u_chan_r (
        .i_clk    (i_clk),
        .i_ctl    (chan_ctl),
        .i_factor (fs_r),
        .i_byte   (byte_r),
        .o_albedo (alb_r)
    );

    btas_chan u_chan_g (
        .i_clk    (i_clk),
        .i_ctl    (chan_ctl),
        .i_factor (fs_g),
        .i_byte   (byte_g),
        .o_albedo (alb_g)
    );

    btas_chan u_chan_b (
        .i_clk    (i_clk),
        .i_ctl    (chan_ctl),
        .i_factor (fs_b),
        .i_byte   (byte_b),
        .o_albedo (alb_b)
    );

    btas_chan u_chan_a (
        .i_clk    (i_clk),
        .i_ctl    (chan_ctl),
        .i_factor (fs_a),
        .i_byte   (byte_a),
        .o_albedo (alb_a)
    );

    assign o_m_tvalid = r_v8;
    assign o_m_tdata  = {4'b0, alb_a, alb_b, alb_g, alb_r};

endmodule

// ===== rtl/btas_chk.sv =====
// Port-level checker for the texel albedo sampler, bound to the top level.
// Depends on btas_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btas_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [btas_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input logic [0:0]                          i_s_tuser,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [btas_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [btas_pkg::CFG_ADDR_W-1:0]     paddr,
    input logic [31:0]                         pwdata,
    input logic [31:0]                         prdata,
    input logic                                pready
);

    localparam logic [btas_pkg::CFG_ADDR_W-1:0] ADDR_FAC_R =
        {btas_pkg::REG_FACTOR_R, 2'b00};

    // a stalled result beat holds
    `BTAS_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")

    // an empty output means the whole pipe can advance
    `BTAS_ASSERT_IMP(a_idle_ready, !o_m_tvalid, o_s_tready, "input stalled with empty output")

    // no channel exceeds one
    `BTAS_ASSERT_IMP(a_out_range, o_m_tvalid, (o_m_tdata[16:0] <= btas_pkg::ONE_Q16) && (o_m_tdata[33:17] <= btas_pkg::ONE_Q16) && (o_m_tdata[50:34] <= btas_pkg::ONE_Q16) && (o_m_tdata[67:51] <= btas_pkg::ONE_Q16), "albedo above one")

    // a factor read right after its write returns the written value
    `BTAS_ASSERT_IMP(a_cfg_readback, (psel && penable && pwrite && pready && paddr == ADDR_FAC_R) ##1 (psel && !pwrite && paddr == ADDR_FAC_R), prdata[16:0] == $past(pwdata[16:0]), "factor readback mismatch")

endmodule

bind barycentric_texel_albedo_sampler btas_chk u_btas_chk (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for barycentric_texel_albedo_sampler: texel writes, UV sampling,
// clamping, nearest-texel fetch and factor scaling, checked against a built-in predictor.
// Depends on btas_pkg and the sampler RTL; drives the stream ports and the APB port.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic        action;
        logic [16:0] wa, wb, wc;
        logic [16:0] au, av, bu, bv, cu, cv;
        logic [15:0] waddr;
        logic [31:0] texel;
    } t_beat;

    typedef struct {
        logic [16:0] red, green, blue, alpha;
    } t_albedo;

    class albedo_tracker;
        logic [8:0]  width_reg, height_reg;
        logic        tex_on, alpha_on;
        logic [16:0] factor_r, factor_g, factor_b, factor_a;
        logic [31:0] texels[int];
        t_albedo     albedo_due[$];
        int          errors, samples, writes, settings;

        function new();
            width_reg  = 9'd1;
            height_reg = 9'd1;
            tex_on     = 1'b0;
            alpha_on   = 1'b0;
            factor_r   = btas_pkg::ONE_Q16;
            factor_g   = btas_pkg::ONE_Q16;
            factor_b   = btas_pkg::ONE_Q16;
            factor_a   = btas_pkg::ONE_Q16;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                btas_pkg::REG_WIDTH:    width_reg  = value[8:0];
                btas_pkg::REG_HEIGHT:   height_reg = value[8:0];
                btas_pkg::REG_TEX_PRES: tex_on     = value[0];
                btas_pkg::REG_ALP_PRES: alpha_on   = value[0];
                btas_pkg::REG_FACTOR_R: factor_r   = value[16:0];
                btas_pkg::REG_FACTOR_G: factor_g   = value[16:0];
                btas_pkg::REG_FACTOR_B: factor_b   = value[16:0];
                btas_pkg::REG_FACTOR_A: factor_a   = value[16:0];
                default: ;
            endcase
        endfunction

        function longint unsigned eff_dim(logic [8:0] d, int lim);
            if (d == 0) return 1;
            return (d > lim) ? lim : d;
        endfunction

        function longint unsigned blend(logic [16:0] w0, w1, w2, c0, c1, c2);
            longint unsigned s;
            s = 64'(w0) * 64'(c0) + 64'(w1) * 64'(c1) + 64'(w2) * 64'(c2);
            return (s > 64'(btas_pkg::ONE_Q32)) ? 64'(btas_pkg::ONE_Q32) : s;
        endfunction

        function int texel_index(t_beat b);
            longint unsigned w, h, u, v, x, y;
            w = eff_dim(width_reg, btas_pkg::MAX_WIDTH);
            h = eff_dim(height_reg, btas_pkg::MAX_HEIGHT);
            u = blend(b.wa, b.wb, b.wc, b.au, b.bu, b.cu);
            v = blend(b.wa, b.wb, b.wc, b.av, b.bv, b.cv);
            x = (u * (w - 1)) >> 32;
            y = (v * (h - 1)) >> 32;
            return int'(y * w + x);
        endfunction

        function logic [16:0] scale(logic [16:0] f, logic [7:0] b8);
            longint unsigned p;
            p = ((f > btas_pkg::ONE_Q16) ? 64'(btas_pkg::ONE_Q16) : 64'(f)) * 64'(b8);
            return 17'((p + 127) / 255);
        endfunction

        function void note_beat(t_beat b);
            logic [31:0] t;
            logic [7:0]  r, g, bl, a;
            int          idx;
            t_albedo     e;
            if (b.action == btas_pkg::ACT_WRITE) begin
                texels[int'(b.waddr)] = b.texel;
                writes++;
                return;
            end
            samples++;
            if (!tex_on) begin
                r  = btas_pkg::BYTE_ONE;
                g  = btas_pkg::BYTE_ONE;
                bl = btas_pkg::BYTE_ONE;
                a  = btas_pkg::BYTE_ONE;
            end else begin
                idx = texel_index(b);
                t = texels.exists(idx) ? texels[idx] : 32'd0;
                r  = t[7:0];
                g  = t[15:8];
                bl = t[23:16];
                a  = alpha_on ? t[31:24] : btas_pkg::BYTE_ONE;
            end
            e.red   = scale(factor_r, r);
            e.green = scale(factor_g, g);
            e.blue  = scale(factor_b, bl);
            e.alpha = scale(factor_a, a);
            albedo_due.push_back(e);
        endfunction

        function void check_albedo(logic [btas_pkg::OUT_TDATA_W-1:0] data);
            t_albedo e;
            if (albedo_due.size() == 0) begin
                $error("albedo beat with none expected: %h", data);
                errors++;
                return;
            end
            e = albedo_due.pop_front();
            if (data[16:0] !== e.red) begin
                $error("albedo_red expected %0d actual %0d", e.red, data[16:0]);
                errors++;
            end
            if (data[33:17] !== e.green) begin
                $error("albedo_green expected %0d actual %0d", e.green, data[33:17]);
                errors++;
            end
            if (data[50:34] !== e.blue) begin
                $error("albedo_blue expected %0d actual %0d", e.blue, data[50:34]);
                errors++;
            end
            if (data[67:51] !== e.alpha) begin
                $error("albedo_alpha expected %0d actual %0d", e.alpha, data[67:51]);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    // weight_a, weight_b, weight_c, vert_a_u, vert_a_v, vert_b_u, vert_b_v,
    // vert_c_u, vert_c_v, write_address, write_texel, zero pad
    logic [btas_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    // action
    logic [0:0]                       i_s_tuser;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    // albedo_red, albedo_green, albedo_blue, albedo_alpha, zero pad
    logic [btas_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                             psel, penable, pwrite;
    logic [btas_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [31:0]                      pwdata, prdata;
    logic                             pready;

    albedo_tracker tracker = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    barycentric_texel_albedo_sampler DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) tracker.check_albedo(o_m_tdata);
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(t_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= b.action;
        i_s_tdata  <= {7'd0, b.texel, b.waddr, b.cv, b.cu, b.bv, b.bu, b.av, b.au,
                       b.wc, b.wb, b.wa};
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_beat(b);
    endtask

    function automatic t_beat noise_beat();
        t_beat b;
        b.action = btas_pkg::ACT_SAMPLE;
        b.wa = 17'($urandom); b.wb = 17'($urandom); b.wc = 17'($urandom);
        b.au = 17'($urandom); b.av = 17'($urandom);
        b.bu = 17'($urandom); b.bv = 17'($urandom);
        b.cu = 17'($urandom); b.cv = 17'($urandom);
        b.waddr = 16'($urandom);
        b.texel = $urandom;
        return b;
    endfunction

    function automatic t_beat point_beat(logic [16:0] u, logic [16:0] v);
        t_beat b;
        b = noise_beat();
        b.wa = btas_pkg::ONE_Q16; b.wb = '0; b.wc = '0;
        b.au = u; b.av = v;
        return b;
    endfunction

    task automatic send_write(int addr, logic [31:0] texel);
        t_beat b;
        b = noise_beat();
        b.action = btas_pkg::ACT_WRITE;
        b.waddr  = 16'(addr);
        b.texel  = texel;
        send_beat(b);
    endtask

    // load the addressed texel first when it has never been written
    task automatic send_sample(t_beat b);
        int idx;
        idx = tracker.texel_index(b);
        if (!tracker.texels.exists(idx)) send_write(idx, $urandom);
        send_beat(b);
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        while (tracker.albedo_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int w, int h, int tex, int alp, int fr, int fg, int fb, int fa);
        hold_until_drained();
        apb_write(btas_pkg::REG_WIDTH, w);
        apb_write(btas_pkg::REG_HEIGHT, h);
        apb_write(btas_pkg::REG_TEX_PRES, tex);
        apb_write(btas_pkg::REG_ALP_PRES, alp);
        apb_write(btas_pkg::REG_FACTOR_R, fr);
        apb_write(btas_pkg::REG_FACTOR_G, fg);
        apb_write(btas_pkg::REG_FACTOR_B, fb);
        apb_write(btas_pkg::REG_FACTOR_A, fa);
        tracker.settings++;
    endtask

    function automatic int rand_factor();
        return ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(65536);
    endfunction

    task automatic random_phase(int count, bit hold_midway);
        t_beat b;
        int    area;
        for (int n = 0; n < count; n++) begin
            if (hold_midway && n == count / 2) hold_until_drained();
            b = noise_beat();
            if ($urandom_range(99) < 30) begin
                b.action = btas_pkg::ACT_WRITE;
                area = tracker.eff_dim(tracker.width_reg, btas_pkg::MAX_WIDTH) *
                       tracker.eff_dim(tracker.height_reg, btas_pkg::MAX_HEIGHT);
                if ($urandom_range(1)) b.waddr = 16'($urandom_range(area - 1));
                send_beat(b);
            end else begin
                if ($urandom_range(99) < 80) begin
                    b.wa = $urandom_range(65536);
                    b.wb = $urandom_range(65536 - b.wa);
                    b.wc = 65536 - b.wa - b.wb;
                    b.au = $urandom_range(65536); b.av = $urandom_range(65536);
                    b.bu = $urandom_range(65536); b.bv = $urandom_range(65536);
                    b.cu = $urandom_range(65536); b.cv = $urandom_range(65536);
                end
                send_sample(b);
            end
        end
    endtask

    initial begin
        t_beat b;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= btas_pkg::ACT_SAMPLE;
        i_m_tready <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: no texture, factors one
        send_sample(point_beat(17'd0, 17'd0));

        configure(256, 256, 1, 1, btas_pkg::ONE_Q16, btas_pkg::ONE_Q16,
                  btas_pkg::ONE_Q16, btas_pkg::ONE_Q16);
        send_write(0, 32'h0000_0000);
        send_write(255, 32'hFFFF_FFFF);
        send_write(65280, 32'h80FF_7F01);
        send_write(65535, 32'h1234_5678);
        send_sample(point_beat(17'd0, 17'd0));
        send_sample(point_beat(btas_pkg::ONE_Q16, 17'd0));
        send_sample(point_beat(17'd0, btas_pkg::ONE_Q16));
        send_sample(point_beat(btas_pkg::ONE_Q16, btas_pkg::ONE_Q16));
        b = noise_beat();
        {b.wa, b.wb, b.wc, b.au, b.av, b.bu, b.bv, b.cu, b.cv} = '1;
        send_sample(b);
        b = point_beat(17'd0, 17'd0);
        b.wa = '0;
        send_sample(b);
        b = point_beat(17'd40000, 17'd50000);
        b.wa = 17'd21845; b.wb = 17'd21845; b.wc = 17'd21846;
        send_sample(b);

        for (int phase = 1; phase <= 8; phase++) begin
            case (phase)
                1: configure(256, 256, 1, 1, btas_pkg::ONE_Q16, btas_pkg::ONE_Q16,
                             btas_pkg::ONE_Q16, btas_pkg::ONE_Q16);
                2: configure(1, 1, 1, 0, rand_factor(), rand_factor(), rand_factor(),
                             rand_factor());
                3: configure(0, 0, 1, 1, 0, 0, 0, 0);
                4: configure(511, 300, 1, 1, 131071, 131071, 131071, 131071);
                5: configure($urandom_range(1, 256), $urandom_range(1, 256), 0,
                             $urandom_range(1), rand_factor(), rand_factor(),
                             rand_factor(), rand_factor());
                6: configure(17, 5, 1, 1, rand_factor(), rand_factor(), rand_factor(),
                             rand_factor());
                7: configure($urandom_range(1, 256), $urandom_range(1, 256), 1, 0,
                             rand_factor(), rand_factor(), rand_factor(), rand_factor());
                default: configure($urandom_range(511), $urandom_range(511), 1,
                                   $urandom_range(1), rand_factor(), rand_factor(),
                                   rand_factor(), rand_factor());
            endcase
            case (phase % 4)
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                3: begin send_idle_pct = 19; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            random_phase(64, phase == 1);
        end

        hold_until_drained();
        if (tracker.albedo_due.size() != 0) begin
            $error("%0d albedo beats never arrived", tracker.albedo_due.size());
            tracker.errors++;
        end
        $display("Run covered %0d texel writes and %0d albedo samples over %0d settings,",
                 tracker.writes, tracker.samples, tracker.settings);
        $display("with clamped UV, out-of-range sizes and factors, and four idle patterns.");
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
